[rtl/core/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Types and codes shared by the sorted timer table front end, engine and
// top level.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Number of timer slots; the slot and timer_id ports are sized for it.
	localparam int TIMER_SLOTS = 16;

	// Request mode codes as they arrive on the input channel.
	localparam logic [2:0] MODE_ADD     = 3'd0;
	localparam logic [2:0] MODE_CANCEL  = 3'd1;
	localparam logic [2:0] MODE_RESET   = 3'd2;
	localparam logic [2:0] MODE_REFRESH = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;
	localparam logic [2:0] MODE_QUERY   = 3'd5;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INACTIVE = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	// Rollover window after reset (one hour in milliseconds).
	localparam logic [31:0] WINDOW_RESET = 32'd3600000;

	// Decoded operation carried through the request queue.
	typedef enum logic [2:0] {
		OP_ADD,
		OP_CANCEL,
		OP_RESET,
		OP_REFRESH,
		OP_TICK,
		OP_QUERY,
		OP_NONE
	} op_t;

	// One queued request.
	typedef struct packed {
		op_t         op;
		logic [3:0]  slot;
		logic [31:0] ivl;
		logic        rep;
		logic        restart_now;
		logic [63:0] now;
	} req_t;

	// One slot record as held in the slot memory.
	typedef struct packed {
		logic        rep;
		logic [31:0] ivl;
		logic [63:0] dl;
	} entry_t;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_WRITE,
		S_SCAN,
		S_FINISH
	} eng_state_t;

endpackage

[rtl/core/sorted_timer_table.sv]
// ----------------------------------------------------------------------------
// sorted_timer_table
// Table of timer slots ordered by deadline and slot number, with add, cancel,
// reset, refresh, expiry tick and next-wait query requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid/in_ready channel, one beat per request,
//   each carrying the current time. They wait in a two-entry queue, so the
//   sender can post a new beat while the engine works on the previous one.
//   Results leave on out_valid/out_ready; every request gives one or more
//   result beats and the final one has last set. An expiry tick gives one
//   beat per fired timer, in deadline order.
//   An add with the notice armed, a query, a reset with the notice armed
//   and a tick on a non-empty table scan the slot memory, one entry read per
//   cycle through its single read port; a tick scans again for each further
//   fired timer. Cancel, refresh, unused modes and the other adds, resets and
//   ticks give their result without a scan.
//   Reset clears all slots, the notice flag and the last tick time, and sets
//   the rollover window to one hour. The window register is written on the
//   cfg channel, which is always ready; the user must write it only while
//   the block is idle, as the block itself does not enforce this.
//   While the receiver stalls, the result register holds its beat and the
//   engine waits before it loads another beat; the queue keeps taking
//   requests until it is full.
// ----------------------------------------------------------------------------
module sorted_timer_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [3:0]  slot,
	input  logic [31:0] interval_ms,
	input  logic        repeat_flag,
	input  logic        restart_now,
	input  logic [63:0] now_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  timer_id,
	output logic [1:0]  status,
	output logic [63:0] wait_ms,
	output logic        front_notice,
	output logic        expired,
	output logic        last
);

	logic          head_valid;
	stt_pkg::req_t head;
	logic          pop;

	// The window register takes a beat in any cycle.
	assign cfg_ready = 1'b1;

	stt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.slot        (slot),
		.interval_ms (interval_ms),
		.repeat_flag (repeat_flag),
		.restart_now (restart_now),
		.now_ms      (now_ms),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	stt_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.timer_id     (timer_id),
		.status       (status),
		.wait_ms      (wait_ms),
		.front_notice (front_notice),
		.expired      (expired),
		.last         (last)
	);

endmodule

[rtl/core/stt_ram.sv]
// ----------------------------------------------------------------------------
// stt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; a read of the address being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/stt_front.sv]
// ----------------------------------------------------------------------------
// stt_front
// Input side: accepts request beats, decodes the mode and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module stt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         mode,
	input  logic [3:0]         slot,
	input  logic [31:0]        interval_ms,
	input  logic               repeat_flag,
	input  logic               restart_now,
	input  logic [63:0]        now_ms,
	output logic               head_valid,
	output stt_pkg::req_t      head,
	input  logic               pop
);

	stt_pkg::req_t  fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	stt_pkg::op_t   op;
	stt_pkg::req_t  req_in;
	logic           push;

	// Mode decoder.
	always_comb begin
		unique case (mode)
			stt_pkg::MODE_ADD:     op = stt_pkg::OP_ADD;
			stt_pkg::MODE_CANCEL:  op = stt_pkg::OP_CANCEL;
			stt_pkg::MODE_RESET:   op = stt_pkg::OP_RESET;
			stt_pkg::MODE_REFRESH: op = stt_pkg::OP_REFRESH;
			stt_pkg::MODE_TICK:    op = stt_pkg::OP_TICK;
			stt_pkg::MODE_QUERY:   op = stt_pkg::OP_QUERY;
			default:               op = stt_pkg::OP_NONE;
		endcase
	end

	always_comb begin
		req_in.op          = op;
		req_in.slot        = slot;
		req_in.ivl         = interval_ms;
		req_in.rep         = repeat_flag;
		req_in.restart_now = restart_now;
		req_in.now         = now_ms;
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req_in;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[rtl/core/stt_engine.sv]
// ----------------------------------------------------------------------------
// stt_engine
// Back end: carries out one request at a time against the slot table, scanning
// the slot memory one entry per cycle to find the earliest deadline, and
// drives the result register.
// ----------------------------------------------------------------------------
module stt_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  stt_pkg::req_t      head,
	output logic               pop,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         timer_id,
	output logic [1:0]         status,
	output logic [63:0]        wait_ms,
	output logic               front_notice,
	output logic               expired,
	output logic               last
);

	localparam int TIMER_SLOTS = stt_pkg::TIMER_SLOTS;
	localparam int SW = $clog2(TIMER_SLOTS);
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int EW = $bits(stt_pkg::entry_t);

	// Control state.
	stt_pkg::eng_state_t   state_q, state_d;
	logic [TIMER_SLOTS-1:0] active_q;
	logic [TIMER_SLOTS-1:0] due_q;
	logic                  notified_q;
	logic [63:0]           prev_q;
	logic [31:0]           window_q;
	logic                  roll_q;
	logic                  first_q;
	stt_pkg::req_t         req_q;
	logic [SW-1:0]         target_q;
	logic [63:0]           start_q;

	// Scan pipeline.
	logic [CW-1:0]         issue_q;
	logic                  cmp_vld_s1;
	logic [SW-1:0]         cmp_idx_s1;
	logic                  best_vld_q;
	logic [SW-1:0]         best_idx_q;
	logic [63:0]           best_dl_q;
	logic [31:0]           best_ivl_q;
	logic                  best_rep_q;

	// Result register.
	logic                  out_valid_q;
	logic [3:0]            timer_id_q;
	logic [1:0]            status_q;
	logic [63:0]           wait_q;
	logic                  fn_q;
	logic                  exp_q;
	logic                  last_q;

	// Memory port.
	logic                  ram_we;
	logic [SW-1:0]         ram_waddr;
	stt_pkg::entry_t       ram_wdata;
	logic [SW-1:0]         ram_raddr;
	logic [EW-1:0]         ram_rdata;
	stt_pkg::entry_t       rd;

	// Sequencer strobes.
	logic                  out_free;
	logic                  res_load;
	logic [3:0]            r_id;
	logic [1:0]            r_st;
	logic [63:0]           r_wait;
	logic                  r_fn;
	logic                  r_exp;
	logic                  r_last;
	logic                  act_set;
	logic                  act_clr;
	logic [SW-1:0]         act_idx;
	logic                  scan_start;
	logic                  tick_init;
	logic                  target_ld;
	logic [SW-1:0]         target_d;
	logic                  notif_set;
	logic                  notif_clr;
	logic                  due_clr;

	// Decode helpers.
	logic                  h_ok, r_ok;
	logic [SW-1:0]         h_idx, r_idx;
	logic                  free_found;
	logic [SW-1:0]         free_idx;
	logic                  scan_done;
	logic [31:0]           old_ivl;
	logic                  fn_hit;
	logic [TIMER_SLOTS-1:0] best_oh;
	logic [TIMER_SLOTS-1:0] due_rest;
	logic                  cand;
	logic                  cand_due;
	logic                  r_active;

	assign rd = stt_pkg::entry_t'(ram_rdata);

	stt_ram #(
		.WIDTH (EW),
		.DEPTH (TIMER_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(ram_wdata)),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Slot decode, free-slot search and scan bookkeeping.
	always_comb begin
		h_ok  = (32'(head.slot) < TIMER_SLOTS);
		r_ok  = (32'(req_q.slot) < TIMER_SLOTS);
		h_idx = SW'(head.slot);
		r_idx = SW'(req_q.slot);
		r_active = r_ok && active_q[r_idx];
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
		out_free  = !out_valid_q || out_ready;
		scan_done = (issue_q == CW'(TIMER_SLOTS)) && !cmp_vld_s1;
		old_ivl   = r_ok ? rd.ivl : 32'd0;
		fn_hit    = best_vld_q && (best_idx_q == target_q) && !notified_q;
		best_oh   = {{(TIMER_SLOTS-1){1'b0}}, 1'b1} << best_idx_q;
		due_rest  = due_q & ~best_oh;
		cand_due  = active_q[cmp_idx_s1] && (roll_q || (rd.dl <= req_q.now));
		if (req_q.op == stt_pkg::OP_TICK) begin
			cand = first_q ? cand_due : due_q[cmp_idx_s1];
		end else begin
			cand = active_q[cmp_idx_s1];
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stt_pkg::S_IDLE: begin
				if (head_valid && out_free) begin
					case (head.op) inside
						stt_pkg::OP_ADD: begin
							if (free_found && !notified_q) begin
								state_d = stt_pkg::S_SCAN;
							end
						end
						stt_pkg::OP_RESET, stt_pkg::OP_REFRESH: state_d = stt_pkg::S_READ;
						stt_pkg::OP_TICK: begin
							if (active_q != '0) begin
								state_d = stt_pkg::S_SCAN;
							end
						end
						stt_pkg::OP_QUERY: state_d = stt_pkg::S_SCAN;
						default: state_d = stt_pkg::S_IDLE;
					endcase
				end
			end
			stt_pkg::S_READ: begin
				if (req_q.op == stt_pkg::OP_RESET
						&& !(req_q.ivl == old_ivl && !req_q.restart_now) && r_active) begin
					state_d = stt_pkg::S_WRITE;
				end else if (out_free) begin
					state_d = stt_pkg::S_IDLE;
				end
			end
			stt_pkg::S_WRITE: begin
				if (!notified_q) begin
					state_d = stt_pkg::S_SCAN;
				end else if (out_free) begin
					state_d = stt_pkg::S_IDLE;
				end
			end
			stt_pkg::S_SCAN: begin
				if (scan_done) begin
					state_d = stt_pkg::S_FINISH;
				end
			end
			stt_pkg::S_FINISH: begin
				if (out_free) begin
					if (req_q.op == stt_pkg::OP_TICK && best_vld_q && (due_rest != '0)) begin
						state_d = stt_pkg::S_SCAN;
					end else begin
						state_d = stt_pkg::S_IDLE;
					end
				end
			end
			default: state_d = stt_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: memory port, result load and state strobes.
	always_comb begin
		pop        = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_raddr  = issue_q[SW-1:0];
		res_load   = 1'b0;
		r_id       = 4'd0;
		r_st       = stt_pkg::STAT_OK;
		r_wait     = 64'd0;
		r_fn       = 1'b0;
		r_exp      = 1'b0;
		r_last     = 1'b1;
		act_set    = 1'b0;
		act_clr    = 1'b0;
		act_idx    = '0;
		scan_start = 1'b0;
		tick_init  = 1'b0;
		target_ld  = 1'b0;
		target_d   = '0;
		notif_set  = 1'b0;
		notif_clr  = 1'b0;
		due_clr    = 1'b0;
		unique case (state_q)
			stt_pkg::S_IDLE: begin
				ram_raddr = h_idx;
				if (head_valid && out_free) begin
					pop = 1'b1;
					case (head.op) inside
						stt_pkg::OP_ADD: begin
							if (!free_found) begin
								res_load = 1'b1;
								r_st     = stt_pkg::STAT_FULL;
							end else begin
								ram_we       = 1'b1;
								ram_waddr    = free_idx;
								ram_wdata.rep = head.rep;
								ram_wdata.ivl = head.ivl;
								ram_wdata.dl  = head.now + 64'(head.ivl);
								act_set      = 1'b1;
								act_idx      = free_idx;
								target_ld    = 1'b1;
								target_d     = free_idx;
								if (notified_q) begin
									res_load = 1'b1;
									r_id     = 4'(free_idx);
								end else begin
									scan_start = 1'b1;
								end
							end
						end
						stt_pkg::OP_CANCEL: begin
							res_load = 1'b1;
							r_id     = head.slot;
							if (h_ok && active_q[h_idx]) begin
								act_clr = 1'b1;
								act_idx = h_idx;
							end else begin
								r_st = stt_pkg::STAT_INACTIVE;
							end
						end
						stt_pkg::OP_TICK: begin
							if (active_q == '0) begin
								res_load = 1'b1;
								r_st     = stt_pkg::STAT_INACTIVE;
							end else begin
								tick_init  = 1'b1;
								scan_start = 1'b1;
							end
						end
						stt_pkg::OP_QUERY: scan_start = 1'b1;
						stt_pkg::OP_RESET, stt_pkg::OP_REFRESH: ;
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			stt_pkg::S_READ: begin
				ram_raddr = r_idx;
				r_id      = req_q.slot;
				if (req_q.op == stt_pkg::OP_RESET) begin
					if (req_q.ivl == old_ivl && !req_q.restart_now) begin
						res_load = out_free;
					end else if (!r_active) begin
						res_load = out_free;
						r_st     = stt_pkg::STAT_INACTIVE;
					end
				end else begin
					res_load = out_free;
					if (!r_active) begin
						r_st = stt_pkg::STAT_INACTIVE;
					end else begin
						ram_we        = 1'b1;
						ram_waddr     = r_idx;
						ram_wdata.rep = rd.rep;
						ram_wdata.ivl = rd.ivl;
						ram_wdata.dl  = req_q.now + 64'(rd.ivl);
					end
				end
			end
			stt_pkg::S_WRITE: begin
				ram_raddr     = r_idx;
				ram_we        = 1'b1;
				ram_waddr     = r_idx;
				ram_wdata.rep = rd.rep;
				ram_wdata.ivl = req_q.ivl;
				ram_wdata.dl  = start_q + 64'(req_q.ivl);
				target_ld     = 1'b1;
				target_d      = r_idx;
				r_id          = req_q.slot;
				if (!notified_q) begin
					scan_start = 1'b1;
				end else begin
					res_load = out_free;
				end
			end
			stt_pkg::S_SCAN: ;
			stt_pkg::S_FINISH: begin
				if (out_free) begin
					res_load = 1'b1;
					case (req_q.op) inside
						stt_pkg::OP_ADD, stt_pkg::OP_RESET: begin
							r_id      = (req_q.op == stt_pkg::OP_ADD) ? 4'(target_q)
								: req_q.slot;
							r_fn      = fn_hit;
							notif_set = fn_hit;
						end
						stt_pkg::OP_QUERY: begin
							notif_clr = 1'b1;
							if (!best_vld_q) begin
								r_wait = '1;
							end else if (req_q.now >= best_dl_q) begin
								r_wait = 64'd0;
							end else begin
								r_wait = best_dl_q - req_q.now;
							end
						end
						stt_pkg::OP_TICK: begin
							if (!best_vld_q) begin
								r_st = stt_pkg::STAT_INACTIVE;
							end else begin
								r_id    = 4'(best_idx_q);
								r_exp   = 1'b1;
								r_last  = (due_rest == '0);
								due_clr = 1'b1;
								if (best_rep_q) begin
									ram_we        = 1'b1;
									ram_waddr     = best_idx_q;
									ram_wdata.rep = best_rep_q;
									ram_wdata.ivl = best_ivl_q;
									ram_wdata.dl  = req_q.now + 64'(best_ivl_q);
								end else begin
									act_clr = 1'b1;
									act_idx = best_idx_q;
								end
								scan_start = (due_rest != '0);
							end
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stt_pkg::S_IDLE;
			active_q    <= '0;
			due_q       <= '0;
			notified_q  <= 1'b0;
			prev_q      <= 64'd0;
			window_q    <= stt_pkg::WINDOW_RESET;
			roll_q      <= 1'b0;
			first_q     <= 1'b0;
			issue_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			best_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			if (act_set) begin
				active_q[act_idx] <= 1'b1;
			end
			if (act_clr) begin
				active_q[act_idx] <= 1'b0;
			end
			if (notif_set) begin
				notified_q <= 1'b1;
			end
			if (notif_clr) begin
				notified_q <= 1'b0;
			end
			if (tick_init) begin
				roll_q  <= (prev_q > head.now) && ((prev_q - head.now) > 64'(window_q));
				prev_q  <= head.now;
				first_q <= 1'b1;
			end else if (due_clr) begin
				first_q <= 1'b0;
			end
			if (due_clr) begin
				due_q[best_idx_q] <= 1'b0;
			end
			// Scan: issue one read per cycle, compare its data in the cycle after.
			if (scan_start) begin
				issue_q    <= '0;
				cmp_vld_s1 <= 1'b0;
				best_vld_q <= 1'b0;
			end else if (state_q == stt_pkg::S_SCAN) begin
				if (issue_q != CW'(TIMER_SLOTS)) begin
					issue_q    <= issue_q + CW'(1);
					cmp_vld_s1 <= 1'b1;
				end else begin
					cmp_vld_s1 <= 1'b0;
				end
				if (cmp_vld_s1) begin
					if (req_q.op == stt_pkg::OP_TICK && first_q) begin
						due_q[cmp_idx_s1] <= cand_due;
					end
					if (cand && (!best_vld_q || rd.dl < best_dl_q)) begin
						best_vld_q <= 1'b1;
					end
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= head;
		end
		if (target_ld) begin
			target_q <= target_d;
		end
		if (state_q == stt_pkg::S_READ) begin
			start_q <= req_q.restart_now ? req_q.now : (rd.dl - 64'(old_ivl));
		end
		if (state_q == stt_pkg::S_SCAN) begin
			cmp_idx_s1 <= issue_q[SW-1:0];
			if (cmp_vld_s1 && cand && (!best_vld_q || rd.dl < best_dl_q)) begin
				best_idx_q <= cmp_idx_s1;
				best_dl_q  <= rd.dl;
				best_ivl_q <= rd.ivl;
				best_rep_q <= rd.rep;
			end
		end
		if (res_load) begin
			timer_id_q <= r_id;
			status_q   <= r_st;
			wait_q     <= r_wait;
			fn_q       <= r_fn;
			exp_q      <= r_exp;
			last_q     <= r_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign timer_id     = timer_id_q;
	assign status       = status_q;
	assign wait_ms      = wait_q;
	assign front_notice = fn_q;
	assign expired      = exp_q;
	assign last         = last_q;

endmodule

[rtl/core/stt_checker.sv]
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks on the result channel of the sorted timer table.
// ----------------------------------------------------------------------------
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  timer_id,
	input logic [1:0]  status,
	input logic [63:0] wait_ms,
	input logic        front_notice,
	input logic        expired,
	input logic        last
);

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(timer_id) && $stable(last))
		else $error("result beat changed while stalled");

	// A fired timer always reports success.
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> status == stt_pkg::STAT_OK && !front_notice)
		else $error("expired beat with bad status");

	// A full table answer is a single beat with no slot.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == stt_pkg::STAT_FULL |-> last && timer_id == 4'd0 && !expired)
		else $error("malformed table-full beat");

	// Only a query reports a wait time.
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wait_ms != 64'd0 |-> !expired && timer_id == 4'd0 && last
			&& status == stt_pkg::STAT_OK)
		else $error("wait time on a non-query beat");

endmodule

bind sorted_timer_table stt_checker u_stt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.timer_id     (timer_id),
	.status       (status),
	.wait_ms      (wait_ms),
	.front_notice (front_notice),
	.expired      (expired),
	.last         (last)
);
